// ----- rtl/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg
// Shared codes and widths for the piecewise-linear spline evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int COORD_W  = 32;   // knot x / y and query width
    localparam int RESULT_W = 48;   // result width, Q32.16

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_INTERP = 2'd1,
        MODE_INTEG  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_ZERO_DX = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

endpackage

// ----- rtl/linear_spline_eval_integrate_top.sv -----
// ----------------------------------------------------------------------------
// linear_spline_eval_integrate_top
// Knot table in two RAMs, bisection search, serial rounding divide and a
// pipelined trapezoid accumulation for the running integral.
// ----------------------------------------------------------------------------
// Interpolation runs its quotient through the one-bit-per-cycle divider;
//   integration adds a trapezoid pass over knots 0 to lo (one RAM read/cycle).
// Throughput: one request in flight; the next is taken once the result sits
//   in the output register.
// Reset: rst_n async low clears control and sets num_knots to 2; the knot
//   RAMs are not cleared and hold garbage until written.
module linear_spline_eval_integrate_top
    import lse_pkg::*;
#(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // knot_index[5:0], knot_abscissa[37:6], knot_ordinate[69:38],
    // query_point[101:70], zero pad
    input  logic [103:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_value[47:0]
    output logic [47:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata
);

    localparam int AW    = $clog2(MAX_KNOTS);
    localparam int NW    = AW + 1;
    localparam int ACC_W = 68 + AW;
    localparam logic [ACC_W-1:0] LIM_POS = ACC_W'((64'd1 << (RESULT_W - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(64'd1 << (RESULT_W - 1));

    typedef enum logic [4:0] {
        S_IDLE, S_RX0, S_RXN, S_CHK, S_BS, S_BSW, S_FB, S_FC, S_EV,
        S_DIVST, S_DIV, S_D, S_LT, S_INT, S_RND, S_SAT, S_DONE
    } state_t;

    state_t state_reg;

    // request fields
    logic [5:0]         f_index;
    logic [31:0]        f_x, f_y, f_z;
    logic               accept;

    assign f_index = s_tdata[5:0];
    assign f_x     = s_tdata[37:6];
    assign f_y     = s_tdata[69:38];
    assign f_z     = s_tdata[101:70];
    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // config
    logic [6:0] nk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nk_reg <= 7'd2;
        end
        else if (cfg_we)
        begin
            nk_reg <= cfg_wdata;
        end
    end

    // clamp knot count to [2, MAX_KNOTS], index of last knot
    logic [AW-1:0] last_idx;
    always_comb
    begin
        if (32'(nk_reg) < 2)
        begin
            last_idx = AW'(1);
        end
        else if (32'(nk_reg) > MAX_KNOTS)
        begin
            last_idx = AW'(MAX_KNOTS - 1);
        end
        else
        begin
            last_idx = AW'(32'(nk_reg) - 1);
        end
    end

    // knot RAMs
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rx, ry;

    assign wr_en = accept && (s_tuser == MODE_WRITE) && (32'(f_index) < MAX_KNOTS);

    lse_ram #(.W(COORD_W), .D(MAX_KNOTS)) u_xram (
        .clk(clk), .we(wr_en), .waddr(AW'(f_index)), .wdata(f_x),
        .raddr(rd_addr), .rdata(rx)
    );
    lse_ram #(.W(COORD_W), .D(MAX_KNOTS)) u_yram (
        .clk(clk), .we(wr_en), .waddr(AW'(f_index)), .wdata(f_y),
        .raddr(rd_addr), .rdata(ry)
    );

    // datapath registers
    logic               integ_reg;
    logic signed [31:0] z_reg;
    logic signed [31:0] x0_reg;
    logic [AW-1:0]      lo_reg, hi_reg, mid_reg;
    logic [31:0]        x_lo_reg, y_lo_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [64:0]        prod_reg;
    logic [32:0]        q_reg;
    logic signed [34:0] tma_reg;
    logic [NW-1:0]      iss_reg;
    logic               p1_reg, p1_first_reg, p2_reg, p3_reg;
    logic [31:0]        prev_x_reg, prev_y_reg;
    logic signed [32:0] sx_reg, sy_reg;
    logic signed [65:0] prod2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               neg_reg;
    logic [ACC_W-1:0]   mag_reg;
    logic               m_tvalid_reg;
    logic [47:0]        res_reg, m_tdata_reg;
    logic [1:0]         st_reg, m_tuser_reg;

    // combinational helpers
    logic [NW-1:0]      mid_sum;
    logic [32:0]        dy_mag;
    logic signed [33:0] d_s;
    logic signed [67:0] lt_prod;
    logic [ACC_W-1:0]   sh_val;
    logic               div_start, div_done;
    logic [65:0]        div_num, div_quot;

    assign mid_sum = (NW'(lo_reg) + NW'(hi_reg)) >> 1;
    assign dy_mag  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign d_s     = dy_reg[32] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign lt_prod = 68'(dz_reg) * 68'(tma_reg);
    assign sh_val  = mag_reg >> (FRAC_BITS + 1);
    assign div_start = (state_reg == S_DIVST);
    assign div_num = 66'(prod_reg) + 66'(dx_reg[32:1]);

    lse_div #(.NW(66), .DW(33)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(33'(dx_reg)), .done(div_done), .quot(div_quot)
    );

    always_comb
    begin
        case (state_reg)
            S_RXN:   rd_addr = last_idx;
            S_BS:    rd_addr = (hi_reg - lo_reg > AW'(1)) ? mid_sum[AW-1:0] : lo_reg;
            S_FB:    rd_addr = lo_reg + 1'b1;
            S_INT:   rd_addr = iss_reg[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            p3_reg       <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        z_reg     <= $signed(f_z);
                        integ_reg <= (s_tuser == MODE_INTEG);
                        res_reg   <= '0;
                        st_reg    <= ST_OK;
                        case (s_tuser)
                            MODE_INTERP, MODE_INTEG: state_reg <= S_RX0;
                            default:                 state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RX0: state_reg <= S_RXN;
                S_RXN:
                begin
                    x0_reg    <= $signed(rx);
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (z_reg < x0_reg || z_reg > $signed(rx))
                    begin
                        st_reg    <= ST_RANGE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= last_idx;
                        state_reg <= S_BS;
                    end
                end
                S_BS:
                begin
                    if (hi_reg - lo_reg > AW'(1))
                    begin
                        mid_reg   <= mid_sum[AW-1:0];
                        state_reg <= S_BSW;
                    end
                    else
                    begin
                        state_reg <= S_FB;
                    end
                end
                S_BSW:
                begin
                    if (z_reg > $signed(rx))
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_BS;
                end
                S_FB:
                begin
                    x_lo_reg  <= rx;
                    y_lo_reg  <= ry;
                    state_reg <= S_FC;
                end
                S_FC:
                begin
                    dx_reg <= $signed({rx[31], rx}) - $signed({x_lo_reg[31], x_lo_reg});
                    dy_reg <= $signed({ry[31], ry}) - $signed({y_lo_reg[31], y_lo_reg});
                    dz_reg <= 33'(z_reg) - $signed({x_lo_reg[31], x_lo_reg});
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    if (dx_reg <= 0)
                    begin
                        st_reg    <= ST_ZERO_DX;
                        state_reg <= S_DONE;
                    end
                    else if (dz_reg < 0 || dz_reg > dx_reg)
                    begin
                        st_reg    <= ST_RANGE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        prod_reg  <= 65'(dy_mag) * 65'(dz_reg[31:0]);
                        state_reg <= S_DIVST;
                    end
                end
                S_DIVST: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        q_reg     <= div_quot[32:0];
                        state_reg <= S_D;
                    end
                end
                S_D:
                begin
                    if (integ_reg)
                    begin
                        tma_reg   <= (35'($signed(y_lo_reg)) <<< 1) + 35'(d_s);
                        state_reg <= S_LT;
                    end
                    else
                    begin
                        res_reg   <= 48'($signed(y_lo_reg)) + 48'(d_s);
                        state_reg <= S_DONE;
                    end
                end
                S_LT:
                begin
                    acc_reg   <= ACC_W'(lt_prod);
                    iss_reg   <= '0;
                    state_reg <= S_INT;
                end
                S_INT:
                begin
                    // stage 0: issue read of knot iss
                    if (iss_reg <= NW'(lo_reg))
                    begin
                        iss_reg      <= iss_reg + 1'b1;
                        p1_reg       <= 1'b1;
                        p1_first_reg <= (iss_reg == '0);
                    end
                    else
                    begin
                        p1_reg <= 1'b0;
                    end
                    // stage 1: form y sum and x width against previous knot
                    if (p1_reg)
                    begin
                        prev_x_reg <= rx;
                        prev_y_reg <= ry;
                        sx_reg <= $signed({rx[31], rx}) - $signed({prev_x_reg[31], prev_x_reg});
                        sy_reg <= $signed({ry[31], ry}) + $signed({prev_y_reg[31], prev_y_reg});
                    end
                    p2_reg <= p1_reg && !p1_first_reg;
                    // stage 2: trapezoid product
                    prod2_reg <= 66'(sx_reg) * 66'(sy_reg);
                    p3_reg    <= p2_reg;
                    // stage 3: accumulate
                    if (p3_reg)
                    begin
                        acc_reg <= acc_reg + ACC_W'(prod2_reg);
                    end
                    if (iss_reg > NW'(lo_reg) && !p1_reg && !p2_reg && !p3_reg)
                    begin
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    neg_reg   <= acc_reg[ACC_W-1];
                    mag_reg   <= (acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg))
                                 + (ACC_W'(1) << FRAC_BITS);
                    state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    if (neg_reg ? (sh_val > LIM_NEG) : (sh_val > LIM_POS))
                    begin
                        st_reg  <= ST_SAT;
                        res_reg <= neg_reg ? LIM_NEG[47:0] : LIM_POS[47:0];
                    end
                    else
                    begin
                        res_reg <= neg_reg ? 48'(-sh_val[47:0]) : sh_val[47:0];
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        m_tuser_reg  <= st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one request in flight
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while busy");

    // divider finishes only while the sequencer waits for it
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("stray divider done");

    // saturated result is one of the two limits
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_SAT) |->
        (m_tdata == 48'h7FFF_FFFF_FFFF || m_tdata == 48'h8000_0000_0000))
        else $error("bad saturation value");

    // error results carry zero
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_ZERO_DX)) |->
        (m_tdata == '0))
        else $error("error result not zero");

endmodule

// ----- rtl/lse_ram.sv -----
// ----------------------------------------------------------------------------
// lse_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lse_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lse_div.sv -----
// ----------------------------------------------------------------------------
// lse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lse_div #(
    parameter int NW = 66,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] sh_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          qbit;

    assign trial = {rem_reg, sh_reg[NW-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[NW-2:0], qbit};
            rem_reg <= qbit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule
